### src/psev_pkg.sv
// Shared constants and types for the postfix stack evaluator.
package psev_pkg;

	localparam int DATA_W          = 32;
	localparam int FRAC_W          = 16;
	localparam int OP_W            = 3;
	localparam int ST_W            = 3;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int DIVD_W          = DATA_W + FRAC_W;

	// operator codes
	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_DIV0    = 3'd1;
	localparam logic [ST_W-1:0] ST_UNDER   = 3'd2;
	localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd3;
	localparam logic [ST_W-1:0] ST_OVER    = 3'd4;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_FROM_UP,
		CM_FROM_DOWN
	} cell_mode_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

### src/psev_cell.sv
// One stack cell: holds an entry, loads from the neighbor above or below.
module psev_cell (
	input  logic                          clk,
	input  psev_pkg::cell_mode_t          mode,
	input  logic [psev_pkg::DATA_W-1:0]   up_in,
	input  logic [psev_pkg::DATA_W-1:0]   down_in,
	output logic [psev_pkg::DATA_W-1:0]   value_q
);
	import psev_pkg::*;

	always_ff @(posedge clk) begin
		case (mode)
			CM_FROM_UP:   value_q <= up_in;
			CM_FROM_DOWN: value_q <= down_in;
			default:      value_q <= value_q;
		endcase
	end

endmodule

### src/psev_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle.
module psev_div (
	input  logic                clk,
	input  logic                arst_n,
	input  psev_pkg::div_req_t  req,
	output psev_pkg::div_rsp_t  rsp
);
	import psev_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DATA_W:0]   trial;

	// remainder stays below the divisor, so shifted it fits DATA_W+1 bits
	assign trial = {rem_q, quo_q[DIVD_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DIVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DIVD_W-1]};
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### src/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: control, arithmetic and the cell stack.
//
// Evaluates a reverse-Polish token stream in signed Q16.16. Each input word carries
// an operator code in s_tuser (0 push, 1 add, 2 subtract, 3 multiply, 4 divide,
// 5..7 unknown) and a number in s_tdata, used only by a push. Every token yields one
// output word: the top of stack (0 if empty), the stack depth and a status (0 ok,
// 1 divide by zero, 2 underflow, 3 unknown operator, 4 overflow). The stack is a row
// of STACK_DEPTH cells; entry 0 is the top and every push or pop shifts the whole
// row by one place at write-back. Tokens are handled one at a time: a multiply
// registers the 32x32 product, then rounds and saturates it in a further step, and
// a divide waits for the restoring divider, which produces one of its 48 quotient
// bits per cycle; a divide by zero skips the divider and finishes like an add.
// The result sits in an output register, so the next token is taken
// as soon as the current one is written back, even if the result is not yet taken;
// write-back waits only while an older result still occupies that register.
// Products round toward minus infinity, quotients truncate toward zero, both
// saturate; add and subtract wrap. A push onto a full stack is dropped.
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [psev_pkg::DATA_W-1:0]       s_tdata,   // [31:0] number
	input  logic [psev_pkg::OP_W-1:0]         s_tuser,   // [2:0] op
	// master side
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// from bit 0: top_value, stack_depth, status, zero fill to whole bytes
	output logic [((psev_pkg::DATA_W + $clog2(STACK_DEPTH + 1) + psev_pkg::ST_W + 7)
		/ 8) * 8 - 1:0]                        m_tdata
);
	import psev_pkg::*;

	localparam int DW  = $clog2(STACK_DEPTH + 1);
	localparam int M_W = $bits(m_tdata);
	localparam logic [DIVD_W-1:0] MAG_MIN = DIVD_W'(1) << (DATA_W - 1);
	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MULR,
		S_DIV,
		S_WB
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [DATA_W-1:0]   num_q;
	logic [DATA_W-1:0]   left_q;
	logic [DATA_W-1:0]   right_q;
	logic                under_q;
	logic                neg_q;
	logic [DATA_W-1:0]   res_q;
	logic [2*DATA_W-1:0] prod_q;
	logic [ST_W-1:0]     st_q;
	logic [DW-1:0]       sp_q;
	div_req_t            div_req_q;
	div_rsp_t            div_rsp;

	logic                m_tvalid_q;
	logic [DATA_W-1:0]   top_q;
	logic [DW-1:0]       depth_q;
	logic [ST_W-1:0]     status_q;

	logic [DATA_W-1:0]   cell_val [STACK_DEPTH];
	logic [DATA_W-1:0]   cell_in;
	cell_mode_t          mode_top;
	cell_mode_t          mode_rest;

	logic                out_free;
	logic                wb_fire;
	logic                is_push;
	logic                full;
	logic [DATA_W-1:0]   left_abs;
	logic [DATA_W-1:0]   right_abs;
	logic [DATA_W-1:0]   mul_sat;
	logic [DATA_W-1:0]   div_sat;
	logic [DW-1:0]       sp_next;
	logic [DATA_W-1:0]   top_next;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign wb_fire  = (state_q == S_WB) && out_free;
	assign is_push  = (op_q == OP_PUSH);
	assign full     = (sp_q == DW'(STACK_DEPTH));

	assign left_abs  = left_q[DATA_W-1]  ? (~left_q + DATA_W'(1))  : left_q;
	assign right_abs = right_q[DATA_W-1] ? (~right_q + DATA_W'(1)) : right_q;

	// floor(product / 2^16): arithmetic shift, saturate if the high bits disagree
	always_comb begin
		if (prod_q[2*DATA_W-1:FRAC_W+DATA_W-1] == '0 ||
		    prod_q[2*DATA_W-1:FRAC_W+DATA_W-1] == '1)
			mul_sat = prod_q[FRAC_W+DATA_W-1:FRAC_W];
		else if (prod_q[2*DATA_W-1])
			mul_sat = SAT_MIN;
		else
			mul_sat = SAT_MAX;
	end

	// sign restore and saturation of the quotient magnitude
	always_comb begin
		if (neg_q) begin
			if (div_rsp.quotient > MAG_MIN)
				div_sat = SAT_MIN;
			else
				div_sat = ~div_rsp.quotient[DATA_W-1:0] + DATA_W'(1);
		end else begin
			if (div_rsp.quotient[DIVD_W-1:DATA_W-1] != '0)
				div_sat = SAT_MAX;
			else
				div_sat = div_rsp.quotient[DATA_W-1:0];
		end
	end

	// depth and top after write-back
	always_comb begin
		if (is_push) begin
			sp_next  = full ? sp_q : sp_q + DW'(1);
			top_next = full ? cell_val[0] : num_q;
		end else begin
			sp_next  = (sp_q < DW'(2)) ? DW'(1) : sp_q - DW'(1);
			top_next = res_q;
		end
	end

	// stack shifting: push moves the row down, an operator pops two and pushes one
	always_comb begin
		cell_in   = is_push ? num_q : res_q;
		mode_top  = CM_HOLD;
		mode_rest = CM_HOLD;
		if (wb_fire) begin
			if (is_push) begin
				if (!full) begin
					mode_top  = CM_FROM_UP;
					mode_rest = CM_FROM_UP;
				end
			end else begin
				mode_top  = CM_FROM_UP;
				mode_rest = CM_FROM_DOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			sp_q            <= '0;
			m_tvalid_q      <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						num_q   <= s_tdata;
						right_q <= (sp_q >= DW'(1)) ? cell_val[0] : '0;
						left_q  <= (sp_q >= DW'(2)) ? cell_val[1] : '0;
						under_q <= (sp_q < DW'(2));
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_q   <= '0;
					state_q <= S_WB;
					if (op_q > OP_DIV)
						st_q <= ST_UNKNOWN;
					else if (op_q == OP_PUSH)
						st_q <= full ? ST_OVER : ST_OK;
					else if (under_q)
						st_q <= ST_UNDER;
					else if (op_q == OP_DIV && right_q == '0)
						st_q <= ST_DIV0;
					else
						st_q <= ST_OK;
					case (op_q)
						OP_ADD: res_q <= left_q + right_q;
						OP_SUB: res_q <= left_q - right_q;
						OP_MUL: begin
							prod_q  <= 64'($signed(left_q) * $signed(right_q));
							state_q <= S_MULR;
						end
						OP_DIV: begin
							if (right_q != '0) begin
								div_req_q.start    <= 1'b1;
								div_req_q.dividend <= {left_abs, {FRAC_W{1'b0}}};
								div_req_q.divisor  <= right_abs;
								neg_q              <= left_q[DATA_W-1] ^ right_q[DATA_W-1];
								state_q            <= S_DIV;
							end
						end
						default: res_q <= '0;
					endcase
				end
				S_MULR: begin
					res_q   <= mul_sat;
					state_q <= S_WB;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						res_q   <= div_sat;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (out_free) begin
						sp_q       <= sp_next;
						top_q      <= top_next;
						depth_q    <= sp_next;
						status_q   <= st_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	psev_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_top
			psev_cell u_cell (
				.clk     (clk),
				.mode    (mode_top),
				.up_in   (cell_in),
				.down_in (cell_val[1]),
				.value_q (cell_val[0])
			);
		end else if (i == STACK_DEPTH - 1) begin : g_bottom
			psev_cell u_cell (
				.clk     (clk),
				.mode    (mode_rest),
				.up_in   (cell_val[i-1]),
				.down_in ({DATA_W{1'b0}}),
				.value_q (cell_val[i])
			);
		end else begin : g_mid
			psev_cell u_cell (
				.clk     (clk),
				.mode    (mode_rest),
				.up_in   (cell_val[i-1]),
				.down_in (cell_val[i+1]),
				.value_q (cell_val[i])
			);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_W'({status_q, depth_q, top_q});

	// the depth counter never passes the number of cells
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond cell count");

	// a waiting result always reports the current depth
	a_depth_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> depth_q == sp_q)
		else $error("reported depth differs from stack pointer");

	// overflow is reported only with a full stack
	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && status_q == ST_OVER) |-> depth_q == DW'(STACK_DEPTH))
		else $error("overflow reported on a stack with room");

	// the divider finishes only while a divide is pending
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider done outside divide step");

endmodule

### tb/postfix_stack_evaluator_tb.sv
// Self-checking testbench for the postfix stack evaluator: random RPN streams, stalls, checks.
`timescale 1ns / 1ps

module postfix_stack_evaluator_tb;
	import psev_pkg::*;

	localparam int DEPTH_W  = $clog2(STACK_DEPTH_DEF + 1);
	localparam int M_W      = ((DATA_W + DEPTH_W + ST_W + 7) / 8) * 8;
	localparam int TAIL_CYC = 60;	// divide is the slowest token

	// operator codes past OP_DIV have no name in the package
	localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;

	// Q16.16 corner values
	localparam logic [DATA_W-1:0] Q_ZERO    = 32'h0000_0000;
	localparam logic [DATA_W-1:0] Q_ULP     = 32'h0000_0001;
	localparam logic [DATA_W-1:0] Q_HALF    = 32'h0000_8000;
	localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hffff_0000;
	localparam logic [DATA_W-1:0] Q_NEG_ULP = 32'hffff_ffff;
	localparam logic [DATA_W-1:0] Q_MAX     = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;

	localparam longint SAT_HI = 2147483647;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] number;
	} token_t;

	typedef struct packed {
		logic [DATA_W-1:0]  top_value;
		logic [DEPTH_W-1:0] stack_depth;
		logic [ST_W-1:0]    status;
	} eval_word_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [DATA_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]    s_tuser  = OP_PUSH;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [M_W-1:0]     m_tdata;

	postfix_stack_evaluator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Mirror of the operand stack and the arithmetic
	// ---------------------------------------------------------------------
	logic [DATA_W-1:0] stack_mirror [STACK_DEPTH_DEF];
	int unsigned       sp_mirror = 0;

	token_t     token_queue [$];	// words waiting for the driver
	eval_word_t due_words [$];	// expected output words, oldest first

	int  tx_idle_pct  = 0;
	int  rx_stall_pct = 0;
	int  hold_left    = 0;	// long receiver hold-off, counted down per cycle
	bit  in_taken     = 1'b0;	// input word accepted at the last rising edge
	bit  failed       = 1'b0;

	// shadow depth seen by the stimulus generator, runs ahead of the DUT
	int  gen_depth    = 0;
	int  fill_left    = 0;

	function automatic logic [DATA_W-1:0] clamp_q(input longint v);
		if (v > SAT_HI)
			return Q_MAX;
		if (v < SAT_LO)
			return Q_MIN;
		return v[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] q_mul(input logic [DATA_W-1:0] a, b);
		longint p;
		p = longint'(signed'(a)) * longint'(signed'(b));
		return clamp_q(p >>> FRAC_W);	// arithmetic shift floors toward -inf
	endfunction

	function automatic logic [DATA_W-1:0] q_div(input logic [DATA_W-1:0] a, b);
		longint n;
		n = longint'(signed'(a)) * 65536;
		return clamp_q(n / longint'(signed'(b)));	// SV division truncates to zero
	endfunction

	// pop into v; an empty stack reads as zero and reports false
	function automatic bit pop_mirror(output logic [DATA_W-1:0] v);
		if (sp_mirror == 0) begin
			v = Q_ZERO;
			return 1'b0;
		end
		sp_mirror--;
		v = stack_mirror[sp_mirror];
		return 1'b1;
	endfunction

	// apply one token to the mirror, return the word the DUT must produce
	function automatic eval_word_t eval_token(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] number);
		eval_word_t        w;
		logic [DATA_W-1:0] rhs, lhs, res;
		bit                got_r, got_l;
		w.status = ST_OK;
		if (op == OP_PUSH) begin
			if (sp_mirror < STACK_DEPTH_DEF) begin
				stack_mirror[sp_mirror] = number;
				sp_mirror++;
			end else begin
				w.status = ST_OVER;	// full stack drops the push
			end
		end else begin
			got_r = pop_mirror(rhs);	// right operand comes off first
			got_l = pop_mirror(lhs);
			res   = Q_ZERO;
			case (op)
				OP_ADD: res = lhs + rhs;
				OP_SUB: res = lhs - rhs;
				OP_MUL: res = q_mul(lhs, rhs);
				OP_DIV: res = (rhs == Q_ZERO) ? Q_ZERO : q_div(lhs, rhs);
				default: res = Q_ZERO;
			endcase
			// priority: unknown op, then underflow, then divide by zero
			if (op > OP_DIV)
				w.status = ST_UNKNOWN;
			else if (!(got_r && got_l))
				w.status = ST_UNDER;
			else if (op == OP_DIV && rhs == Q_ZERO)
				w.status = ST_DIV0;
			// either an entry came off or the stack was empty, so the push fits
			stack_mirror[sp_mirror] = res;
			sp_mirror++;
		end
		w.top_value   = (sp_mirror == 0) ? Q_ZERO : stack_mirror[sp_mirror - 1];
		w.stack_depth = sp_mirror[DEPTH_W-1:0];
		return w;
	endfunction

	// ---------------------------------------------------------------------
	// Driver and receiver, both on the falling edge
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		token_t t;
		if (arst_n && (!s_tvalid || in_taken)) begin
			in_taken = 1'b0;
			if (token_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				t = token_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= t.op;
				s_tdata  <= t.number;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
	end

	// long hold-off: runs on its own while the driver keeps offering words
	always @(negedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// ---------------------------------------------------------------------
	// Monitor: predict on input acceptance, check on output acceptance
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		eval_word_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				due_words.push_back(eval_token(s_tuser, s_tdata));
				in_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.top_value   = m_tdata[DATA_W-1:0];
				got.stack_depth = m_tdata[DATA_W +: DEPTH_W];
				got.status      = m_tdata[DATA_W + DEPTH_W +: ST_W];
				if (due_words.size() == 0) begin
					$error("output word with none expected: top_value %h", got.top_value);
					failed = 1'b1;
				end else begin
					want = due_words.pop_front();
					if (got.top_value !== want.top_value) begin
						$error("top_value: expected %h, got %h", want.top_value,
							got.top_value);
						failed = 1'b1;
					end
					if (got.stack_depth !== want.stack_depth) begin
						$error("stack_depth: expected %0d, got %0d", want.stack_depth,
							got.stack_depth);
						failed = 1'b1;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	task automatic queue_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] number);
		token_t t;
		t.op     = op;
		t.number = number;
		token_queue.push_back(t);
		if (op == OP_PUSH)
			gen_depth = (gen_depth < STACK_DEPTH_DEF) ? gen_depth + 1 : gen_depth;
		else
			gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 1;
	endtask

	// mix of corner values, small magnitudes (products stay in range) and raw words
	function automatic logic [DATA_W-1:0] rand_q();
		logic [DATA_W-1:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0, 1: begin
				case ($urandom_range(7))
					0: return Q_ZERO;
					1: return Q_ULP;
					2: return Q_HALF;
					3: return Q_ONE;
					4: return Q_NEG_ONE;
					5: return Q_NEG_ULP;
					6: return Q_MAX;
					default: return Q_MIN;
				endcase
			end
			2, 3, 4, 5: return {{8{r[23]}}, r[23:0]};
			default: return r;
		endcase
	endfunction

	task automatic queue_random(input int n);
		logic [OP_W-1:0] op;
		int              push_pct;
		repeat (n) begin
			if (fill_left > 0) begin
				// fill burst runs the stack past full to hit overflow
				op = OP_PUSH;
				fill_left--;
			end else begin
				if ($urandom_range(149) == 0)
					fill_left = STACK_DEPTH_DEF + 2 - gen_depth;
				push_pct = (gen_depth < 2) ? 80 : 45;
				if ($urandom_range(99) < push_pct)
					op = OP_PUSH;
				else if ($urandom_range(9) == 0)
					op = OP_W'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
				else
					op = OP_W'($urandom_range(OP_DIV, OP_ADD));
			end
			// operators carry junk in the number field, it must be ignored
			queue_token(op, (op == OP_PUSH) ? rand_q() : $urandom);
		end
	endtask

	// sender stays quiet until every expected word has come back
	task automatic drain();
		while (token_queue.size() != 0 || s_tvalid || due_words.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed: errors on an empty stack first
		set_idling(0, 0);
		queue_token(OP_BAD_LAST, Q_MAX);	// unknown wins over underflow
		queue_token(OP_DIV, Q_ZERO);	// underflow wins over divide by zero
		queue_token(OP_SUB, Q_ZERO);
		// add and subtract wrap
		queue_token(OP_PUSH, Q_MAX);
		queue_token(OP_PUSH, Q_ULP);
		queue_token(OP_ADD, Q_ZERO);
		queue_token(OP_PUSH, Q_ULP);
		queue_token(OP_SUB, Q_ZERO);
		// product saturates high and low, then a negative product floors
		queue_token(OP_PUSH, Q_MAX);
		queue_token(OP_MUL, Q_ZERO);
		queue_token(OP_PUSH, Q_MIN);
		queue_token(OP_MUL, Q_ZERO);
		queue_token(OP_PUSH, Q_NEG_ULP);
		queue_token(OP_PUSH, Q_HALF);
		queue_token(OP_MUL, Q_ZERO);
		// divide by zero, then quotient saturation from a positive and a negative pair
		queue_token(OP_PUSH, Q_ZERO);
		queue_token(OP_DIV, Q_ZERO);
		queue_token(OP_PUSH, Q_MAX);
		queue_token(OP_PUSH, Q_ULP);
		queue_token(OP_DIV, Q_ZERO);
		queue_token(OP_PUSH, Q_MIN);
		queue_token(OP_PUSH, Q_NEG_ULP);
		queue_token(OP_DIV, Q_ZERO);
		// remaining unknown codes with operands present
		for (int c = OP_BAD_FIRST; c < OP_BAD_LAST; c++)
			queue_token(OP_W'(c), Q_ONE);
		drain();

		// random phases
		queue_random(100);
		drain();
		set_idling(73, 0);
		queue_random(90);
		drain();
		set_idling(0, 73);
		queue_random(90);
		drain();
		set_idling(14, 14);
		queue_random(90);
		drain();

		// receiver holds off while the sender keeps going: input must back up
		set_idling(0, 0);
		hold_left = 300;
		queue_random(40);
		drain();

		set_idling(14, 14);
		queue_random(15);
		drain();

		repeat (TAIL_CYC) @(posedge clk);
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// timeout far above the slowest correct run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
